### design/rv32i_dec_pkg.sv
package rv32i_dec_pkg;

  // Major opcodes, bits 6:0 of the instruction
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;

  // funct7 values
  localparam logic [6:0] FUNCT7_BASE = 7'h00;
  localparam logic [6:0] FUNCT7_ALT  = 7'h20;

  // funct3 values
  localparam logic [2:0] F3_0 = 3'd0;
  localparam logic [2:0] F3_1 = 3'd1;
  localparam logic [2:0] F3_2 = 3'd2;
  localparam logic [2:0] F3_3 = 3'd3;
  localparam logic [2:0] F3_4 = 3'd4;
  localparam logic [2:0] F3_5 = 3'd5;
  localparam logic [2:0] F3_6 = 3'd6;
  localparam logic [2:0] F3_7 = 3'd7;

  localparam int unsigned OP_W  = 6;
  localparam int unsigned FMT_W = 3;
  localparam int unsigned REG_W = 5;
  localparam int unsigned XLEN  = 32;

  typedef enum logic [OP_W-1:0] {
    OP_INVALID = 6'd0,
    OP_LUI     = 6'd1,
    OP_AUIPC   = 6'd2,
    OP_JAL     = 6'd3,
    OP_JALR    = 6'd4,
    OP_BEQ     = 6'd5,
    OP_BNE     = 6'd6,
    OP_BLT     = 6'd7,
    OP_BGE     = 6'd8,
    OP_BLTU    = 6'd9,
    OP_BGEU    = 6'd10,
    OP_LB      = 6'd11,
    OP_LH      = 6'd12,
    OP_LW      = 6'd13,
    OP_LBU     = 6'd14,
    OP_LHU     = 6'd15,
    OP_SB      = 6'd16,
    OP_SH      = 6'd17,
    OP_SW      = 6'd18,
    OP_ADDI    = 6'd19,
    OP_SLTI    = 6'd20,
    OP_SLTIU   = 6'd21,
    OP_XORI    = 6'd22,
    OP_ORI     = 6'd23,
    OP_ANDI    = 6'd24,
    OP_SLLI    = 6'd25,
    OP_SRLI    = 6'd26,
    OP_SRAI    = 6'd27,
    OP_ADD     = 6'd28,
    OP_SUB     = 6'd29,
    OP_SLL     = 6'd30,
    OP_SLT     = 6'd31,
    OP_SLTU    = 6'd32,
    OP_XOR     = 6'd33,
    OP_SRL     = 6'd34,
    OP_SRA     = 6'd35,
    OP_OR      = 6'd36,
    OP_AND     = 6'd37
  } op_e;

  typedef enum logic [FMT_W-1:0] {
    FMT_NONE = 3'd0,
    FMT_R    = 3'd1,
    FMT_I    = 3'd2,
    FMT_S    = 3'd3,
    FMT_B    = 3'd4,
    FMT_U    = 3'd5,
    FMT_J    = 3'd6
  } fmt_e;

  // Decoded word
  typedef struct packed {
    op_e                     operation;
    fmt_e                    format;
    logic [REG_W-1:0]        dest_reg;
    logic [REG_W-1:0]        src1_reg;
    logic [REG_W-1:0]        src2_reg;
    logic signed [XLEN-1:0]  immediate;
    logic                    reads_src1;
    logic                    reads_src2;
    logic                    writes_dest;
  } dec_t;

endpackage

### design/rv32i_dec_in_if.sv
interface rv32i_dec_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction_word;

  modport source (output valid, output instruction_word, input ready);
  modport sink   (input valid, input instruction_word, output ready);
endinterface

### design/rv32i_dec_out_if.sv
interface rv32i_dec_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         operation;
  logic [2:0]         format;
  logic [4:0]         dest_reg;
  logic [4:0]         src1_reg;
  logic [4:0]         src2_reg;
  logic signed [31:0] immediate;
  logic               reads_src1;
  logic               reads_src2;
  logic               writes_dest;

  modport source (
    output valid, output operation, output format, output dest_reg,
    output src1_reg, output src2_reg, output immediate,
    output reads_src1, output reads_src2, output writes_dest,
    input  ready
  );
  modport sink (
    input  valid, input operation, input format, input dest_reg,
    input  src1_reg, input src2_reg, input immediate,
    input  reads_src1, input reads_src2, input writes_dest,
    output ready
  );
endinterface

### design/rv32i_dec_core.sv
module rv32i_dec_core (
  input  logic [rv32i_dec_pkg::XLEN-1:0] word_i,
  output rv32i_dec_pkg::dec_t            dec_o
);
  import rv32i_dec_pkg::*;

  logic [6:0]      opcode;
  logic [2:0]      f3;
  logic [6:0]      f7;
  logic [XLEN-1:0] imm_i, imm_s, imm_b, imm_u, imm_j, imm_sh;
  op_e             op;
  fmt_e            fmt;
  logic [XLEN-1:0] imm;
  logic            use_rs1, use_rs2, use_rd;

  assign opcode = word_i[6:0];
  assign f3     = word_i[14:12];
  assign f7     = word_i[31:25];

  // Immediate forms
  assign imm_i  = {{20{word_i[31]}}, word_i[31:20]};
  assign imm_s  = {{20{word_i[31]}}, word_i[31:25], word_i[11:7]};
  assign imm_b  = {{19{word_i[31]}}, word_i[31], word_i[7], word_i[30:25],
                   word_i[11:8], 1'b0};
  assign imm_u  = {word_i[31:12], 12'b0};
  assign imm_j  = {{11{word_i[31]}}, word_i[31], word_i[19:12], word_i[20],
                   word_i[30:21], 1'b0};
  assign imm_sh = {27'b0, word_i[24:20]};

  // Operation, format and register usage
  always_comb begin
    op      = OP_INVALID;
    fmt     = FMT_NONE;
    imm     = '0;
    use_rs1 = 1'b0;
    use_rs2 = 1'b0;
    use_rd  = 1'b0;
    unique case (opcode)
      OPC_LUI, OPC_AUIPC: begin
        op     = (opcode == OPC_LUI) ? OP_LUI : OP_AUIPC;
        fmt    = FMT_U;
        imm    = imm_u;
        use_rd = 1'b1;
      end
      OPC_JAL: begin
        op     = OP_JAL;
        fmt    = FMT_J;
        imm    = imm_j;
        use_rd = 1'b1;
      end
      OPC_JALR: begin
        op      = (f3 == F3_0) ? OP_JALR : OP_INVALID;
        fmt     = FMT_I;
        imm     = imm_i;
        use_rd  = 1'b1;
        use_rs1 = 1'b1;
      end
      OPC_BRANCH: begin
        unique case (f3)
          F3_0:    op = OP_BEQ;
          F3_1:    op = OP_BNE;
          F3_4:    op = OP_BLT;
          F3_5:    op = OP_BGE;
          F3_6:    op = OP_BLTU;
          F3_7:    op = OP_BGEU;
          default: op = OP_INVALID;
        endcase
        fmt     = FMT_B;
        imm     = imm_b;
        use_rs1 = 1'b1;
        use_rs2 = 1'b1;
      end
      OPC_LOAD: begin
        unique case (f3)
          F3_0:    op = OP_LB;
          F3_1:    op = OP_LH;
          F3_2:    op = OP_LW;
          F3_4:    op = OP_LBU;
          F3_5:    op = OP_LHU;
          default: op = OP_INVALID;
        endcase
        fmt     = FMT_I;
        imm     = imm_i;
        use_rd  = 1'b1;
        use_rs1 = 1'b1;
      end
      OPC_STORE: begin
        unique case (f3)
          F3_0:    op = OP_SB;
          F3_1:    op = OP_SH;
          F3_2:    op = OP_SW;
          default: op = OP_INVALID;
        endcase
        fmt     = FMT_S;
        imm     = imm_s;
        use_rs1 = 1'b1;
        use_rs2 = 1'b1;
      end
      OPC_OPIMM: begin
        imm = imm_i;
        unique case (f3)
          F3_0: op = OP_ADDI;
          F3_2: op = OP_SLTI;
          F3_3: op = OP_SLTIU;
          F3_4: op = OP_XORI;
          F3_6: op = OP_ORI;
          F3_7: op = OP_ANDI;
          F3_1: begin
            imm = imm_sh;
            op  = (f7 == FUNCT7_BASE) ? OP_SLLI : OP_INVALID;
          end
          default: begin
            // shift right: logical or arithmetic by funct7
            imm = imm_sh;
            if (f7 == FUNCT7_BASE) begin
              op = OP_SRLI;
            end else if (f7 == FUNCT7_ALT) begin
              op = OP_SRAI;
            end else begin
              op = OP_INVALID;
            end
          end
        endcase
        fmt     = FMT_I;
        use_rd  = 1'b1;
        use_rs1 = 1'b1;
      end
      OPC_OP: begin
        if (f7 == FUNCT7_BASE) begin
          unique case (f3)
            F3_0:    op = OP_ADD;
            F3_1:    op = OP_SLL;
            F3_2:    op = OP_SLT;
            F3_3:    op = OP_SLTU;
            F3_4:    op = OP_XOR;
            F3_5:    op = OP_SRL;
            F3_6:    op = OP_OR;
            default: op = OP_AND;
          endcase
        end else if (f7 == FUNCT7_ALT && f3 == F3_0) begin
          op = OP_SUB;
        end else if (f7 == FUNCT7_ALT && f3 == F3_5) begin
          op = OP_SRA;
        end else begin
          op = OP_INVALID;
        end
        fmt     = FMT_R;
        use_rd  = 1'b1;
        use_rs1 = 1'b1;
        use_rs2 = 1'b1;
      end
      default: begin
        op = OP_INVALID;
      end
    endcase
  end

  // Assemble the result; an invalid word clears every field
  always_comb begin
    dec_o = '0;
    if (op != OP_INVALID) begin
      dec_o.operation   = op;
      dec_o.format      = fmt;
      dec_o.immediate   = imm;
      dec_o.dest_reg    = use_rd  ? word_i[11:7]  : '0;
      dec_o.src1_reg    = use_rs1 ? word_i[19:15] : '0;
      dec_o.src2_reg    = use_rs2 ? word_i[24:20] : '0;
      dec_o.writes_dest = use_rd;
      dec_o.reads_src1  = use_rs1;
      dec_o.reads_src2  = use_rs2;
    end
  end

endmodule

### design/rv32i_instruction_decoder_unit.sv
// RV32I instruction decoder.
// instr_i carries one 32-bit instruction word per handshake; dec_o returns
// one decoded word per instruction: operation, format, register indices,
// sign-extended immediate (shift amount for immediate shifts) and the
// register-use flags. Unknown or illegal encodings come out as operation
// invalid with every other field zero.
// Both channels complete a transfer when valid and ready are high at a
// rising clock edge.
// An accepted instruction passes the input register, the decode logic and
// the result register in that order before it is shown on dec_o. While
// dec_o.ready is high, throughput is one instruction per cycle, set by the
// two register stages, each loading whenever it is empty or being drained.
// When the receiver holds ready low the result register holds its word,
// the input register fills behind it, and instr_i.ready drops once both
// are occupied; no word is lost or repeated.
// Reset (rst_ni low, asynchronous) empties both stages.
module rv32i_instruction_decoder_unit (
  input logic              clk_i,
  input logic              rst_ni,
  rv32i_dec_in_if.sink     instr_i,
  rv32i_dec_out_if.source  dec_o
);
  import rv32i_dec_pkg::*;

  logic            in_valid_q;
  logic [XLEN-1:0] word_q;
  logic            out_valid_q;
  dec_t            res_q;
  dec_t            res_d;
  logic            out_ready;
  logic            in_ready;

  // Stage handshakes: a stage loads when empty or when drained this cycle
  assign out_ready     = !out_valid_q || dec_o.ready;
  assign in_ready      = !in_valid_q || out_ready;
  assign instr_i.ready = in_ready;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= instr_i.valid;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Input word register
  always_ff @(posedge clk_i) begin
    if (in_ready && instr_i.valid) begin
      word_q <= instr_i.instruction_word;
    end
  end

  // Decode logic
  rv32i_dec_core u_core (
    .word_i (word_q),
    .dec_o  (res_d)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (out_ready && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign dec_o.valid       = out_valid_q;
  assign dec_o.operation   = res_q.operation;
  assign dec_o.format      = res_q.format;
  assign dec_o.dest_reg    = res_q.dest_reg;
  assign dec_o.src1_reg    = res_q.src1_reg;
  assign dec_o.src2_reg    = res_q.src2_reg;
  assign dec_o.immediate   = res_q.immediate;
  assign dec_o.reads_src1  = res_q.reads_src1;
  assign dec_o.reads_src2  = res_q.reads_src2;
  assign dec_o.writes_dest = res_q.writes_dest;

endmodule
